[rtl/gss_pkg.sv]
// gss_pkg: shared constants and polynomial coefficient tables for the smoothstep pipeline
`timescale 1ns / 1ps

package gss_pkg;

    // number of polynomial terms, powers 0 to 13
    localparam int NPOW      = 14;
    // horner accumulator width, 24 fraction bits
    localparam int ACC_W     = 48;
    // number of defined orders
    localparam int NORD      = 7;
    localparam logic [2:0] ORDER_LINEAR = 3'd0;
    localparam logic [2:0] ORDER_TOP    = 3'd6;

    // configuration register indexes
    localparam logic [1:0] REG_LOWER_EDGE = 2'd0;
    localparam logic [1:0] REG_UPPER_EDGE = 2'd1;
    localparam logic [1:0] REG_ORDER      = 2'd2;

    // step polynomial coefficients, power 0 first
    localparam logic signed [31:0] STEP_COEF [NORD][NPOW] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 3, -2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 10, -15, 6, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 35, -84, 70, -20, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 126, -420, 540, -315, 70, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 462, -1980, 3465, -3080, 1386, -252, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 1716, -9009, 20020, -24024, 16380, -6006, 924}
    };

    // derivative polynomial coefficients, power 0 first
    localparam logic signed [31:0] SLOPE_COEF [NORD][NPOW] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 6, -6, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 30, -60, 30, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 140, -420, 420, -140, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 630, -2520, 3780, -2520, 630, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 2772, -13860, 27720, -27720, 13860, -2772, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 12012, -72072, 180180, -240240, 180180, -72072, 12012, 0}
    };

    // order seven behaves as order six
    function automatic logic [2:0] clip_order(input logic [2:0] ord);
        return (ord > ORDER_TOP) ? ORDER_TOP : ord;
    endfunction

    function automatic logic signed [31:0] step_coef(input logic [2:0] ord,
                                                     input logic [3:0] pw);
        return STEP_COEF[clip_order(ord)][pw];
    endfunction

    function automatic logic signed [31:0] slope_coef(input logic [2:0] ord,
                                                      input logic [3:0] pw);
        return SLOPE_COEF[clip_order(ord)][pw];
    endfunction

endpackage

[rtl/generalized_smoothstep_with_slope_top.sv]
// generalized_smoothstep_with_slope_top: pipelined smoothstep with slope, stream ports
`timescale 1ns / 1ps

// Maps each signed Q16.16 sample to t = (sample - lower_edge) / (upper_edge - lower_edge),
// clamped to [0,1], and returns the generalized smoothstep of the configured order (Q1.16)
// with its derivative over the edge span (signed Q16.16, saturating, with a flag). Equal
// edges give zero outputs and raise span_error. The block takes one item per clock while
// the output is not stalled. It chains a 16-step restoring divider for t, 14 Horner
// steps of two stages each (split multiply, then add), and a 33-step restoring divider for
// the slope. A stall on the output holds the whole pipeline. Configuration must be written
// through cfg_wen/cfg_index/cfg_data only while no item is in flight, a rule for the user
// that the block does not enforce; the edge span is registered in the cycle after a write.
module generalized_smoothstep_with_slope_top
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [16:0] step_value, [48:17] slope, [55:49] zero
    output logic [1:0]  m_tuser    // [0] slope_saturated, [1] span_error
);
    import gss_pkg::*;

    localparam int TDIV = 16;
    localparam int QDIV = 33;

    logic ce;

    // configuration registers
    logic signed [31:0] lower_reg;
    logic signed [31:0] upper_reg;
    logic [2:0]         order_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= 32'sd0;
            upper_reg <= 32'sd65536;
            order_reg <= 3'd1;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_LOWER_EDGE: lower_reg <= cfg_data;
                REG_UPPER_EDGE: upper_reg <= cfg_data;
                REG_ORDER:      order_reg <= cfg_data[2:0];
                default:        ;
            endcase
        end
    end

    // span magnitude and direction
    logic signed [32:0] span_full;
    logic [31:0]        span_abs_reg;
    logic               span_neg_reg;
    logic               span_zero_reg;

    assign span_full = {upper_reg[31], upper_reg} - {lower_reg[31], lower_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_abs_reg  <= 32'd65536;
            span_neg_reg  <= 1'b0;
            span_zero_reg <= 1'b0;
        end
        else
        begin
            span_abs_reg  <= span_full[32] ? 32'(-span_full) : span_full[31:0];
            span_neg_reg  <= span_full[32];
            span_zero_reg <= (span_full == 33'sd0);
        end
    end

    // global stall: advance whenever the output register can take an item
    logic out_valid_reg;
    assign ce       = !out_valid_reg || m_tready;
    assign s_tready = ce;

    // input register
    logic               v0_reg;
    logic signed [31:0] x0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (ce)
            v0_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            x0_reg <= s_tdata;
    end

    // offset from the lower edge, flipped for a falling span
    logic               v1_reg;
    logic signed [33:0] n1_reg;
    logic signed [33:0] diff1;

    assign diff1 = 34'(x0_reg) - 34'(lower_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (ce)
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            n1_reg <= span_neg_reg ? -diff1 : diff1;
    end

    // clamp detection and divider set-up for t
    logic        dv_reg  [TDIV+1];
    logic [32:0] dr_reg  [TDIV+1];
    logic [15:0] dq_reg  [TDIV+1];
    logic        dcl_reg [TDIV+1];
    logic [16:0] dcv_reg [TDIV+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg[0] <= 1'b0;
        else if (ce)
            dv_reg[0] <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            dr_reg[0] <= n1_reg[32:0];
            dq_reg[0] <= 16'd0;
            if (n1_reg <= 34'sd0)
            begin
                dcl_reg[0] <= 1'b1;
                dcv_reg[0] <= 17'd0;
            end
            else if (n1_reg >= $signed({2'b00, span_abs_reg}))
            begin
                dcl_reg[0] <= 1'b1;
                dcv_reg[0] <= 17'd65536;
            end
            else
            begin
                dcl_reg[0] <= 1'b0;
                dcv_reg[0] <= 17'd0;
            end
        end
    end

    // restoring divider for t, one quotient bit a stage
    for (genvar k = 0; k < TDIV; k++)
    begin : g_tdiv
        logic [32:0] r2;
        logic        ge;

        assign r2 = {dr_reg[k][31:0], 1'b0};
        assign ge = (r2 >= {1'b0, span_abs_reg});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[k+1] <= 1'b0;
            else if (ce)
                dv_reg[k+1] <= dv_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                dr_reg[k+1]  <= ge ? (r2 - {1'b0, span_abs_reg}) : r2;
                dq_reg[k+1]  <= {dq_reg[k][14:0], ge};
                dcl_reg[k+1] <= dcl_reg[k];
                dcv_reg[k+1] <= dcv_reg[k];
            end
        end
    end

    // horner chain, two stages a step: split multiply, then round and add
    logic                    hv   [NPOW+1];
    logic [16:0]             ht   [NPOW+1];
    logic signed [ACC_W-1:0] hs   [NPOW+1];
    logic signed [ACC_W-1:0] hd   [NPOW+1];

    assign hv[0] = dv_reg[TDIV];
    assign ht[0] = dcl_reg[TDIV] ? dcv_reg[TDIV] : {1'b0, dq_reg[TDIV]};
    assign hs[0] = '0;
    assign hd[0] = '0;

    for (genvar j = 0; j < NPOW; j++)
    begin : g_horner
        logic               mv_reg;
        logic [16:0]        mt_reg;
        logic [40:0]        mlo_s_reg;
        logic signed [41:0] mhi_s_reg;
        logic [40:0]        mlo_d_reg;
        logic signed [41:0] mhi_d_reg;
        logic               av_reg;
        logic [16:0]        at_reg;
        logic signed [ACC_W-1:0] as_reg;
        logic signed [ACC_W-1:0] ad_reg;
        logic signed [65:0] sum_s;
        logic signed [65:0] sum_d;
        logic signed [65:0] sh_s;
        logic signed [65:0] sh_d;
        logic signed [ACC_W-1:0] cs;
        logic signed [ACC_W-1:0] cd;
        logic [3:0]         pw;

        assign pw = 4'(NPOW - 1 - j);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                mv_reg <= 1'b0;
                av_reg <= 1'b0;
            end
            else if (ce)
            begin
                mv_reg <= hv[j];
                av_reg <= mv_reg;
            end
        end

        // partial products of accumulator and t
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                mt_reg    <= ht[j];
                mlo_s_reg <= hs[j][23:0] * ht[j];
                mhi_s_reg <= $signed(hs[j][ACC_W-1:24]) * $signed({1'b0, ht[j]});
                mlo_d_reg <= hd[j][23:0] * ht[j];
                mhi_d_reg <= $signed(hd[j][ACC_W-1:24]) * $signed({1'b0, ht[j]});
            end
        end

        // recombine, round half up, drop 16 bits, add the coefficient
        always_comb
        begin
            sum_s = $signed({mhi_s_reg, 24'b0}) + $signed({25'b0, mlo_s_reg}) + 66'sd32768;
            sum_d = $signed({mhi_d_reg, 24'b0}) + $signed({25'b0, mlo_d_reg}) + 66'sd32768;
            sh_s  = sum_s >>> 16;
            sh_d  = sum_d >>> 16;
            cs    = ACC_W'(step_coef(order_reg, pw)) <<< 24;
            cd    = ACC_W'(slope_coef(order_reg, pw)) <<< 24;
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                at_reg <= mt_reg;
                as_reg <= sh_s[ACC_W-1:0] + cs;
                ad_reg <= sh_d[ACC_W-1:0] + cd;
            end
        end

        assign hv[j+1] = av_reg;
        assign ht[j+1] = at_reg;
        assign hs[j+1] = as_reg;
        assign hd[j+1] = ad_reg;
    end

    // final step value and clamped derivative
    logic                    fv_reg;
    logic [16:0]             fs_reg;
    logic [46:0]             fds_reg;
    logic signed [ACC_W-1:0] s_round;
    logic [16:0]             s_next;
    logic [46:0]             ds_next;

    always_comb
    begin
        s_round = (hs[NPOW] + ACC_W'(128)) >>> 8;
        if (order_reg == ORDER_LINEAR)
        begin
            s_next  = ht[NPOW];
            ds_next = (ht[NPOW] != 17'd0 && ht[NPOW] != 17'd65536) ? 47'd16777216 : 47'd0;
        end
        else
        begin
            if (s_round < 0)
                s_next = 17'd0;
            else if (s_round > ACC_W'(65536))
                s_next = 17'd65536;
            else
                s_next = s_round[16:0];
            ds_next = hd[NPOW][ACC_W-1] ? 47'd0 : hd[NPOW][46:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else if (ce)
            fv_reg <= hv[NPOW];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            fs_reg  <= s_next;
            fds_reg <= ds_next;
        end
    end

    // slope divider set-up: round(ds*256/d) as floor((ds*512 + d) / 2d)
    logic [56:0] num;
    logic [32:0] den;

    assign num = (57'(fds_reg) << 9) + 57'(span_abs_reg);
    assign den = {span_abs_reg, 1'b0};

    logic        ev_reg   [QDIV+1];
    logic [32:0] er_reg   [QDIV+1];
    logic [32:0] eq_reg   [QDIV+1];
    logic [32:0] enum_reg [QDIV+1];
    logic        eovf_reg [QDIV+1];
    logic [16:0] es_reg   [QDIV+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ev_reg[0] <= 1'b0;
        else if (ce)
            ev_reg[0] <= fv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            er_reg[0]   <= 33'(num[56:33]);
            eq_reg[0]   <= 33'd0;
            enum_reg[0] <= num[32:0];
            eovf_reg[0] <= (33'(num[56:33]) >= den);
            es_reg[0]   <= fs_reg;
        end
    end

    // restoring divider for the slope magnitude
    for (genvar k = 0; k < QDIV; k++)
    begin : g_qdiv
        logic [33:0] r2;
        logic        ge;

        assign r2 = {er_reg[k], enum_reg[k][QDIV-1-k]};
        assign ge = (r2 >= {1'b0, den});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ev_reg[k+1] <= 1'b0;
            else if (ce)
                ev_reg[k+1] <= ev_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                er_reg[k+1]   <= ge ? 33'(r2 - {1'b0, den}) : r2[32:0];
                eq_reg[k+1]   <= {eq_reg[k][31:0], ge};
                enum_reg[k+1] <= enum_reg[k];
                eovf_reg[k+1] <= eovf_reg[k];
                es_reg[k+1]   <= es_reg[k];
            end
        end
    end

    // sign and saturation of the slope; the equal-edge case is handled at the output register
    logic [32:0] qmag;
    logic        sat;
    logic [31:0] slope_next;

    always_comb
    begin
        qmag = eq_reg[QDIV];
        if (span_neg_reg)
        begin
            sat        = eovf_reg[QDIV] || (qmag > 33'h080000000);
            slope_next = sat ? 32'h80000000 : 32'(-qmag);
        end
        else
        begin
            sat        = eovf_reg[QDIV] || (qmag > 33'h07FFFFFFF);
            slope_next = sat ? 32'h7FFFFFFF : qmag[31:0];
        end
    end

    // output register
    logic [16:0] out_step_reg;
    logic [31:0] out_slope_reg;
    logic        out_sat_reg;
    logic        out_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ce)
            out_valid_reg <= ev_reg[QDIV];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            if (span_zero_reg)
            begin
                out_step_reg  <= 17'd0;
                out_slope_reg <= 32'd0;
                out_sat_reg   <= 1'b0;
                out_err_reg   <= 1'b1;
            end
            else
            begin
                out_step_reg  <= es_reg[QDIV];
                out_slope_reg <= slope_next;
                out_sat_reg   <= sat;
                out_err_reg   <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_slope_reg, out_step_reg};
    assign m_tuser  = {out_err_reg, out_sat_reg};

endmodule

[dv/tb.sv]
// tb: self-checking testbench for the generalized smoothstep with slope block
`timescale 1ns / 1ps

module tb;
    import gss_pkg::*;

    localparam int LATENCY   = 83;
    localparam int CYC_LIMIT = 900000;

    logic        clk;
    logic        rst_n;
    logic        cfg_wen;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;

    typedef struct packed {
        logic [16:0] step_value;
        logic [31:0] slope;
        logic        slope_saturated;
        logic        span_error;
    } gss_result_t;

    // model copy of the registers
    logic signed [31:0] edge_lo;
    logic signed [31:0] edge_hi;
    logic [2:0]         order_sel;

    logic [31:0] sample_q [$];
    gss_result_t result_q [$];
    int          err_count = 0;
    int          cycle_count = 0;
    int          send_wait;
    int          recv_wait;
    int          hold_cycles;
    logic        hold_req;
    logic        hold_taken;

    generalized_smoothstep_with_slope_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // floor division by 2^s for signed values
    function automatic longint shift_floor(input longint v, input int s);
        return v >>> s;
    endfunction

    // horner evaluation of one coefficient row, 24 fraction bits
    function automatic longint eval_poly(input logic [2:0] ord, input logic is_slope,
                                         input longint t);
        longint acc;
        longint c;
        acc = 0;
        for (int p = NPOW - 1; p >= 0; p--)
        begin
            c = is_slope ? SLOPE_COEF[ord][p] : STEP_COEF[ord][p];
            acc = shift_floor(acc * t + 32768, 16) + c * 64'sd16777216;
        end
        return acc;
    endfunction

    // expected outputs for one sample under the current registers
    function automatic gss_result_t predict_smoothstep(input logic [31:0] smp);
        gss_result_t r;
        longint d, n, t, s, ds, mag;
        logic   neg;
        logic [2:0] ord;
        r = '0;
        d = longint'(edge_hi) - longint'(edge_lo);
        n = longint'($signed(smp)) - longint'(edge_lo);
        neg = 1'b0;
        if (d == 0)
        begin
            r.span_error = 1'b1;
            return r;
        end
        if (d < 0)
        begin
            d = -d;
            n = -n;
            neg = 1'b1;
        end
        if (n <= 0)
            t = 0;
        else if (n >= d)
            t = 65536;
        else
            t = (n * 65536) / d;
        ord = (order_sel > ORDER_TOP) ? ORDER_TOP : order_sel;
        if (ord == ORDER_LINEAR)
        begin
            s = t;
            ds = (t > 0 && t < 65536) ? 64'sd16777216 : 0;
        end
        else
        begin
            s = shift_floor(eval_poly(ord, 1'b0, t) + 128, 8);
            if (s < 0)
                s = 0;
            if (s > 65536)
                s = 65536;
            ds = eval_poly(ord, 1'b1, t);
            if (ds < 0)
                ds = 0;
        end
        mag = (ds * 512 + d) / (2 * d);
        if (neg)
        begin
            if (mag > 64'sh80000000)
            begin
                mag = 64'sh80000000;
                r.slope_saturated = 1'b1;
            end
            r.slope = 32'(-mag);
        end
        else
        begin
            if (mag > 64'sh7FFFFFFF)
            begin
                mag = 64'sh7FFFFFFF;
                r.slope_saturated = 1'b1;
            end
            r.slope = 32'(mag);
        end
        r.step_value = 17'(s);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        err_count++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            send_wait <= 0;
        end
        else if (s_tvalid && !s_tready)
        begin
            // hold item
        end
        else if (send_wait > 0)
        begin
            s_tvalid  <= 1'b0;
            send_wait <= send_wait - 1;
        end
        else if (sample_q.size() > 0)
        begin
            s_tvalid  <= 1'b1;
            s_tdata   <= sample_q.pop_front();
            send_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 0;
        end
        else
            s_tvalid <= 1'b0;
    end

    // prediction at input acceptance
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            result_q.push_back(predict_smoothstep(s_tdata));
    end

    // monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        gss_result_t want;
        int          gap;
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                    report_mismatch("unexpected item", m_tdata, 0);
                else
                begin
                    want = result_q.pop_front();
                    if (m_tdata[16:0] !== want.step_value)
                        report_mismatch("step_value", m_tdata[16:0], want.step_value);
                    if (m_tdata[48:17] !== want.slope)
                        report_mismatch("slope", m_tdata[48:17], want.slope);
                    if (m_tdata[55:49] !== 7'd0)
                        report_mismatch("pad", m_tdata[55:49], 0);
                    if (m_tuser[0] !== want.slope_saturated)
                        report_mismatch("slope_saturated", m_tuser[0], want.slope_saturated);
                    if (m_tuser[1] !== want.span_error)
                        report_mismatch("span_error", m_tuser[1], want.span_error);
                end
            end
            if (hold_cycles > 0)
                m_tready <= 1'b0;
            else if (recv_wait > 0)
            begin
                m_tready  <= 1'b0;
                recv_wait <= recv_wait - 1;
            end
            else if (m_tvalid && m_tready)
            begin
                // receiver pauses for a random gap before the next item
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 0;
                recv_wait <= (gap > 0) ? gap - 1 : 0;
                m_tready  <= (gap == 0);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cycles <= 0;
            hold_taken  <= 1'b0;
        end
        else if (hold_req && !hold_taken)
        begin
            hold_cycles <= 400;
            hold_taken  <= 1'b1;
        end
        else if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYC_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        case (idx)
            REG_LOWER_EDGE: edge_lo = val;
            REG_UPPER_EDGE: edge_hi = val;
            REG_ORDER:      order_sel = val[2:0];
            default: ;
        endcase
        repeat (2) @(posedge clk);
    endtask

    task automatic drain_pipe;
        while (sample_q.size() > 0 || s_tvalid || result_q.size() > 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_near(input logic signed [31:0] lo,
                                              input logic signed [31:0] hi);
        longint span;
        span = longint'(hi) - longint'(lo);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return lo + $signed(32'($urandom_range(0, 8))) - 4;
            2: return hi + $signed(32'($urandom_range(0, 8))) - 4;
            default:
                return 32'(longint'(lo) - span / 8
                       + ((span * 5 / 4) * longint'($urandom_range(0, 65535))) / 65536);
        endcase
    endfunction

    // stimulus
    initial
    begin
        logic signed [31:0] lo, hi;
        int                 n_items;
        cfg_wen     = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        hold_req    = 1'b0;
        edge_lo     = 0;
        edge_hi     = 65536;
        order_sel   = 3'd1;
        rst_n       = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset registers, edges of range and field extremes
        sample_q.push_back(32'h0000_0000);
        sample_q.push_back(32'h0001_0000);
        sample_q.push_back(32'h0000_8000);
        sample_q.push_back(32'h0000_0001);
        sample_q.push_back(32'h0000_FFFF);
        sample_q.push_back(32'h8000_0000);
        sample_q.push_back(32'h7FFF_FFFF);
        sample_q.push_back(32'hFFFF_FFFF);
        drain_pipe();

        // linear order with a wide span: tiny offsets truncate t to zero
        write_reg(REG_ORDER, 32'(ORDER_LINEAR));
        write_reg(REG_LOWER_EDGE, 32'h8000_0000);
        write_reg(REG_UPPER_EDGE, 32'h7FFF_FFFF);
        sample_q.push_back(32'h8000_0001);
        sample_q.push_back(32'h0000_0000);
        sample_q.push_back(32'h7FFF_FFFE);
        sample_q.push_back(32'h7FFF_FFFF);
        drain_pipe();

        // equal edges, then reversed narrow span for slope saturation, order seven
        write_reg(REG_UPPER_EDGE, 32'h8000_0000);
        sample_q.push_back(32'h1234_5678);
        sample_q.push_back(32'h8000_0000);
        drain_pipe();
        write_reg(REG_ORDER, 32'd7);
        write_reg(REG_LOWER_EDGE, 32'h0000_0002);
        write_reg(REG_UPPER_EDGE, 32'h0000_0000);
        sample_q.push_back(32'h0000_0001);
        sample_q.push_back(32'h0000_0002);
        sample_q.push_back(32'h0000_0000);
        drain_pipe();
        write_reg(REG_ORDER, 32'(ORDER_TOP));
        write_reg(REG_UPPER_EDGE, 32'h0000_0004);
        sample_q.push_back(32'h0000_0003);
        sample_q.push_back(32'h0000_0002);
        drain_pipe();

        // random phases over orders and edges
        for (int ph = 0; ph < 29; ph++)
        begin
            case (ph % 4)
                0: begin lo = $urandom; hi = $urandom; end
                1: begin lo = $signed(32'($urandom_range(0, 131072))) - 65536;
                         hi = lo + $signed(32'($urandom_range(1, 200000))); end
                2: begin lo = $signed(32'($urandom_range(0, 64))) - 32;
                         hi = lo - $signed(32'($urandom_range(1, 40))); end
                default: begin lo = 32'h8000_0000 + $urandom_range(0, 3);
                               hi = 32'h7FFF_FFFF - $urandom_range(0, 3); end
            endcase
            if (ph == 13)
                hi = lo;
            write_reg(REG_LOWER_EDGE, lo);
            write_reg(REG_UPPER_EDGE, hi);
            write_reg(REG_ORDER, 32'($urandom_range(0, 7)));
            // more items in the hold-off phase so the block fills and stalls its input
            n_items = (ph == 5) ? 120 : 48;
            for (int k = 0; k < n_items; k++)
                sample_q.push_back(rand_near(lo, hi));
            if (ph == 5)
                hold_req = 1'b1;
            drain_pipe();
        end

        repeat (LATENCY + 20) @(posedge clk);
        if (result_q.size() != 0)
            report_mismatch("items left over", result_q.size(), 0);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/gss_pkg.sv
rtl/generalized_smoothstep_with_slope_top.sv
dv/tb.sv
